[design/tspr_pkg.sv]
// Shared types and constants for the transport-stream sync and PID router.
// No dependencies; every other design file but tspr_checker refers to this package by scoped name.
`timescale 1ns / 1ps

package tspr_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'h47;
    localparam logic [4:0] PID_HI_MASK = 5'h1F;
    localparam int         PID_W       = 13;
    localparam int         PCOUNT_W    = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_BYPASS    = 3'd0;
    localparam logic [2:0] REG_PID_COUNT = 3'd1;
    localparam logic [2:0] REG_PID_SLOT0 = 3'd2;

    // Result queue sizing: one input byte pushes at most three results
    localparam int QUEUE_DEPTH = 6;
    localparam int QCNT_W      = 3;
    localparam int MAX_PUSH    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_cipher;
        logic       packet_first;
        logic       packet_last;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     item;
    } push_t;

    typedef struct packed {
        logic                bypass;
        logic [PCOUNT_W-1:0] pid_count;
    } cfg_ctrl_t;

endpackage

[design/tspr_cfg_regs.sv]
// APB register file: bypass, slot count and PID slot registers.
// Depends on tspr_pkg.
`timescale 1ns / 1ps

module tspr_cfg_regs #(
    parameter int PID_SLOTS = 6
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [4:0]                               paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    output tspr_pkg::cfg_ctrl_t                      ctrl,
    output logic [PID_SLOTS-1:0][tspr_pkg::PID_W-1:0] pid_slots
);

    logic                                     bypass_reg;
    logic [tspr_pkg::PCOUNT_W-1:0]            pid_count_reg;
    logic [PID_SLOTS-1:0][tspr_pkg::PID_W-1:0] slot_reg;
    logic [2:0]                               reg_index;
    logic [2:0]                               slot_sel;
    logic                                     wr_en;
    logic                                     slot_range;

    assign pready     = 1'b1;
    assign reg_index  = paddr[4:2];
    assign wr_en      = psel && penable && pwrite;
    assign slot_sel   = reg_index - tspr_pkg::REG_PID_SLOT0;
    assign slot_range = reg_index >= tspr_pkg::REG_PID_SLOT0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg    <= 1'b0;
            pid_count_reg <= '0;
            slot_reg      <= '0;
        end
        else if (wr_en)
        begin
            if (reg_index == tspr_pkg::REG_BYPASS)
                bypass_reg <= pwdata[0];
            if (reg_index == tspr_pkg::REG_PID_COUNT)
                pid_count_reg <= pwdata[tspr_pkg::PCOUNT_W-1:0];
            for (int i = 0; i < PID_SLOTS; i++)
            begin
                if (slot_range && slot_sel == 3'(i))
                    slot_reg[i] <= pwdata[tspr_pkg::PID_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            tspr_pkg::REG_BYPASS:    prdata = {31'b0, bypass_reg};
            tspr_pkg::REG_PID_COUNT: prdata = {{(32-tspr_pkg::PCOUNT_W){1'b0}}, pid_count_reg};
            default:
            begin
                for (int i = 0; i < PID_SLOTS; i++)
                begin
                    if (slot_sel == 3'(i))
                        prdata = {{(32-tspr_pkg::PID_W){1'b0}}, slot_reg[i]};
                end
            end
        endcase
    end

    assign ctrl.bypass    = bypass_reg;
    assign ctrl.pid_count = pid_count_reg;
    assign pid_slots      = slot_reg;

endmodule

[design/tspr_framer.sv]
// Sync hunt, packet framing and PID match; produces up to three results per byte.
// Depends on tspr_pkg.
`timescale 1ns / 1ps

module tspr_framer #(
    parameter int PACKET_BYTES = 188,
    parameter int PID_SLOTS    = 6
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      accept,
    input  logic [7:0]                                data_byte,
    input  tspr_pkg::cfg_ctrl_t                       ctrl,
    input  logic [PID_SLOTS-1:0][tspr_pkg::PID_W-1:0] pid_slots,
    output tspr_pkg::push_t                           push
);

    localparam logic [7:0] LAST_INDEX = 8'(PACKET_BYTES - 1);

    logic       in_packet_reg, in_packet_next;
    logic [7:0] byte_index_reg, byte_index_next;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic       cipher_reg, cipher_next;
    logic [tspr_pkg::PID_W-1:0] pid;
    logic       pid_hit;
    logic       last;

    assign pid  = {held1_reg[4:0] & tspr_pkg::PID_HI_MASK, data_byte};
    assign last = byte_index_reg >= LAST_INDEX;

    // Parallel compare against the slots in use
    always_comb
    begin
        pid_hit = 1'b0;
        for (int i = 0; i < PID_SLOTS; i++)
        begin
            if (3'(i) < ctrl.pid_count && pid_slots[i] == pid)
                pid_hit = 1'b1;
        end
    end

    always_comb
    begin
        in_packet_next  = in_packet_reg;
        byte_index_next = byte_index_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        cipher_next     = cipher_reg;
        push            = '0;
        if (accept)
        begin
            if (ctrl.bypass)
            begin
                in_packet_next  = 1'b0;
                byte_index_next = '0;
                push.count      = 2'd1;
                push.item[0]    = '{data_byte, 1'b0, 1'b0, 1'b0, 1'b1};
            end
            else if (!in_packet_reg)
            begin
                if (data_byte == tspr_pkg::SYNC_BYTE)
                begin
                    in_packet_next  = 1'b1;
                    held0_next      = data_byte;
                    byte_index_next = 8'd1;
                end
            end
            else if (byte_index_reg == 8'd1)
            begin
                held1_next      = data_byte;
                byte_index_next = 8'd2;
            end
            else if (byte_index_reg == 8'd2)
            begin
                cipher_next     = pid_hit;
                byte_index_next = 8'd3;
                push.count      = 2'd3;
                push.item[0]    = '{held0_reg, pid_hit, 1'b1, 1'b0, 1'b0};
                push.item[1]    = '{held1_reg, pid_hit, 1'b0, 1'b0, 1'b0};
                push.item[2]    = '{data_byte, pid_hit, 1'b0, 1'b0, 1'b1};
            end
            else
            begin
                push.count   = 2'd1;
                push.item[0] = '{data_byte, cipher_reg, 1'b0, last, 1'b1};
                if (last)
                begin
                    in_packet_next  = 1'b0;
                    byte_index_next = '0;
                end
                else
                begin
                    byte_index_next = byte_index_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg  <= 1'b0;
            byte_index_reg <= '0;
            held0_reg      <= '0;
            held1_reg      <= '0;
            cipher_reg     <= 1'b0;
        end
        else
        begin
            in_packet_reg  <= in_packet_next;
            byte_index_reg <= byte_index_next;
            held0_reg      <= held0_next;
            held1_reg      <= held1_next;
            cipher_reg     <= cipher_next;
        end
    end

endmodule

[design/tspr_out_queue.sv]
// Shifting result queue; entry 0 is the output register.
// Depends on tspr_pkg.
`timescale 1ns / 1ps

module tspr_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tspr_pkg::push_t   push,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tspr_pkg::result_t out_item
);

    localparam int DEPTH = tspr_pkg::QUEUE_DEPTH;
    localparam int CW    = tspr_pkg::QCNT_W;

    tspr_pkg::result_t [DEPTH-1:0] q_reg, q_next;
    tspr_pkg::result_t [DEPTH-1:0] shifted;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] base;
    logic          pop;

    assign out_valid = count_reg != '0;
    assign out_item  = q_reg[0];
    assign pop       = out_valid && out_ready;
    // Keep room for the largest push
    assign in_ready  = count_reg <= CW'(DEPTH - tspr_pkg::MAX_PUSH);
    assign base      = count_reg - {{(CW-1){1'b0}}, pop};

    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
            shifted[i] = pop ? q_reg[i+1] : q_reg[i];
        shifted[DEPTH-1] = q_reg[DEPTH-1];
        q_next = shifted;
        for (int i = 0; i < DEPTH; i++)
        begin
            for (int k = 0; k < tspr_pkg::MAX_PUSH; k++)
            begin
                if (2'(k) < push.count && (base + CW'(k)) == CW'(i))
                    q_next[i] = push.item[k];
            end
        end
        count_next = base + {{(CW-2){1'b0}}, push.count};
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

[design/ts_packet_sync_pid_router_top.sv]
// Top level of the transport-stream sync and PID router.
// Depends on tspr_pkg, tspr_cfg_regs, tspr_framer and tspr_out_queue.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_*): one raw transport-stream byte per transfer.
//   Master stream (m_*): packet bytes in stream order; tuser carries the
//   routing flags, tlast marks the final byte of each packet.
//   APB port: bypass at 0x00, slot count at 0x04, PID slots 0..5 at 0x08..0x1C.
//   While hunting, bytes other than 0x47 are dropped. Bytes 0 and 1 of a
//   packet are held until byte 2 gives the PID; then all three leave back to
//   back, followed by one result per later byte, each tagged to_cipher when
//   the PID matches an enabled slot. Bypass forwards every byte with only run_last set.
// Timing
//   Results are registered in the queue, whose entry 0 drives m_* directly;
//   the three results of byte 2 leave one after another.
//   Throughput: one byte per cycle while s_tready is high; the six-entry
//   result queue drops s_tready only while more than three results wait.
// Reset and stall
//   rst_n clears the queue, framing state and registers (hunting, bypass off,
//   no slots in use). When the receiver stalls, the queue holds the head
//   result steady and fills; s_tready falls once it cannot take a full push.
module ts_packet_sync_pid_router_top #(
    parameter int PACKET_BYTES = 188,
    parameter int PID_SLOTS    = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [0] to_cipher, [1] packet_first, [2] run_last
    output logic        m_tlast,   // packet_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tspr_pkg::cfg_ctrl_t                       ctrl;
    logic [PID_SLOTS-1:0][tspr_pkg::PID_W-1:0] pid_slots;
    tspr_pkg::push_t                           push;
    tspr_pkg::result_t                         head;
    logic                                      accept;

    // A transfer on the slave side advances the framer
    assign accept = s_tvalid && s_tready;

    tspr_cfg_regs #(
        .PID_SLOTS (PID_SLOTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .ctrl      (ctrl),
        .pid_slots (pid_slots)
    );

    tspr_framer #(
        .PACKET_BYTES (PACKET_BYTES),
        .PID_SLOTS    (PID_SLOTS)
    ) u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .ctrl      (ctrl),
        .pid_slots (pid_slots),
        .push      (push)
    );

    // Results wait here so input keeps flowing while the receiver stalls
    tspr_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = {head.run_last, head.packet_first, head.to_cipher};
    assign m_tlast = head.packet_last;

endmodule

[design/tspr_checker.sv]
// Port-level checks for the router, bound to the top level.
// Depends on ts_packet_sync_pid_router_top port names only.
`timescale 1ns / 1ps

module tspr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // Stalled output holds valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // Stalled output holds its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // A sync byte result is never the last result of its run nor the final packet byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[2] && !m_tlast)
        else $error("packet_first on the last result of a run");

    // The final packet byte ends its run and is never marked packet_first
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[2] && !m_tuser[1])
        else $error("packet_last without run_last");

    // Input backpressure only comes from queued results
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with nothing to send");

endmodule

bind ts_packet_sync_pid_router_top tspr_checker u_tspr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
